/* rtl/isingm_pkg.sv */
// Shared constants, command codes and control structs for the Ising spin update block.
// No dependencies; isingm_nbr, isingm_update and the top module import this package.
package isingm_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int SITE_W      = 12;
	localparam int RND_W       = 32;
	localparam int CMD_W       = 2;
	localparam int CFG_N       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int DE_W        = 6;
	localparam int MAG_W       = 14;
	localparam int EN_W        = 15;
	localparam int EQ_W        = 4;
	localparam int NB_W        = 34;
	localparam int RECIP_SHIFT = 24;

	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// sites held in the store: SIDE^DIMS, capped at the store depth
	function automatic int site_total(input int side, input int dims);
		int n;
		n = 1;
		for (int d = 0; d < dims; d++) begin
			n = n * side;
			if (n > STORE_DEPTH) begin
				n = STORE_DEPTH;
			end
		end
		return n;
	endfunction

	typedef struct packed {
		logic load;
		logic mul;
		logic div;
	} nbr_ctrl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [RND_W-1:0] rnd;
		logic             wval;
		logic             me;
		logic             in_range;
	} upd_req_t;

endpackage

/* rtl/isingm_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module isingm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic [AW-1:0]    addr,
	input  logic             we,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/isingm_nbr.sv */
// Neighbour address unit: peels one lattice coordinate per dimension off the site
// index by reciprocal multiplication and forms the two wrap-around neighbours.
// Depends on isingm_pkg.
module isingm_nbr #(
	parameter int SIDE   = 64,
	parameter int NSITES = 4096
) (
	input  logic                         clk,
	input  isingm_pkg::nbr_ctrl_t        ctl,
	input  logic [isingm_pkg::SITE_W-1:0] site,
	output logic [isingm_pkg::NB_W-1:0]  up_idx,
	output logic [isingm_pkg::NB_W-1:0]  dn_idx,
	output logic                         up_oob,
	output logic                         dn_oob
);
	import isingm_pkg::*;

	localparam int RECIP_W = RECIP_SHIFT;
	localparam int PROD_W  = SITE_W + RECIP_W;
	localparam int CW      = $clog2(SIDE);
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'((2 ** RECIP_SHIFT + SIDE - 1) / SIDE);

	logic [SITE_W-1:0] site_q;
	logic [SITE_W-1:0] r_q;
	logic [PROD_W-1:0] prod_q;
	logic [NB_W-1:0]   stride_q;
	logic [NB_W-1:0]   span_q;
	logic [NB_W-1:0]   up_q;
	logic [NB_W-1:0]   dn_q;

	logic [SITE_W-1:0] q_est;
	logic [SITE_W-1:0] rem_est;
	logic [SITE_W-1:0] q_fix;
	logic [SITE_W-1:0] rem_fix;
	logic [CW-1:0]     coord;
	logic [NB_W-1:0]   site_x;
	logic [NB_W-1:0]   up_next;
	logic [NB_W-1:0]   dn_next;

	always_comb begin
		q_est   = prod_q[RECIP_SHIFT +: SITE_W];
		rem_est = r_q - SITE_W'(q_est * SIDE);
		// correct an estimate that came out one short
		if (rem_est >= SITE_W'(SIDE)) begin
			q_fix   = q_est + SITE_W'(1);
			rem_fix = rem_est - SITE_W'(SIDE);
		end else begin
			q_fix   = q_est;
			rem_fix = rem_est;
		end
		coord   = rem_fix[CW-1:0];
		site_x  = NB_W'(site_q);
		up_next = (coord == CW'(SIDE - 1)) ? site_x - span_q : site_x + stride_q;
		dn_next = (coord == '0) ? site_x + span_q : site_x - stride_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			site_q   <= site;
			r_q      <= site;
			stride_q <= NB_W'(1);
			span_q   <= NB_W'(SIDE - 1);
		end else if (ctl.div) begin
			r_q      <= q_fix;
			stride_q <= NB_W'(stride_q * SIDE);
			span_q   <= NB_W'(span_q * SIDE);
		end
		if (ctl.mul) begin
			prod_q <= {{RECIP_W{1'b0}}, r_q} * {{SITE_W{1'b0}}, RECIP_V};
		end
		if (ctl.div) begin
			up_q <= up_next;
			dn_q <= dn_next;
		end
	end

	assign up_idx = up_q;
	assign dn_idx = dn_q;
	assign up_oob = up_q >= NB_W'(NSITES);
	assign dn_oob = dn_q >= NB_W'(NSITES);

endmodule

/* rtl/isingm_update.sv */
// Flip decision, acceptance thresholds, running magnetization and energy, result register.
// Depends on isingm_pkg.
module isingm_update #(
	parameter int DIMS   = 2,
	parameter int NSITES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [isingm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [isingm_pkg::RND_W-1:0]        cfg_data,
	input  logic                                fire,
	input  isingm_pkg::upd_req_t                req,
	input  logic [isingm_pkg::EQ_W-1:0]         eq_cnt,
	output logic                                wr_en,
	output logic                                wr_spin,
	output logic                                done,
	output logic                                flipped,
	output logic signed [isingm_pkg::DE_W-1:0]  delta_energy,
	output logic                                spin_now,
	output logic signed [isingm_pkg::MAG_W-1:0] magnetization_sum,
	output logic signed [isingm_pkg::EN_W-1:0]  energy_sum
);
	import isingm_pkg::*;

	localparam logic [MAG_W-1:0] MAG_UP    = MAG_W'(2);
	localparam logic [MAG_W-1:0] MAG_DN    = MAG_W'(-2);
	localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(-NSITES);
	localparam logic [EN_W-1:0]  EN_RESET  = EN_W'(-DIMS * NSITES);

	logic [RND_W-1:0]     thr_q [CFG_N];
	logic [MAG_W-1:0]     mag_q;
	logic [EN_W-1:0]      en_q;
	logic                 done_q;
	logic                 flipped_q;
	logic [DE_W-1:0]      de_q;
	logic                 spin_q;

	logic [DE_W-1:0]      de;
	logic                 uphill;
	logic [CFG_IDX_W-1:0] slot;
	logic                 accept;
	logic                 newv;
	logic                 change;

	always_comb begin
		// dE = 4 * (equal neighbours) - 4 * DIMS, taken modulo the field width
		de     = {eq_cnt, 2'b00} - DE_W'(4 * DIMS);
		uphill = eq_cnt > EQ_W'(DIMS);
		slot   = CFG_IDX_W'(eq_cnt - EQ_W'(DIMS) - EQ_W'(1));
		accept = !uphill || (req.rnd < thr_q[slot]);
		unique case (req.cmd)
			CMD_STEP:  newv = req.me ^ accept;
			CMD_WRITE: newv = req.wval;
			default:   newv = req.me;
		endcase
		change = req.in_range && (newv != req.me);
	end

	assign wr_en   = fire && change;
	assign wr_spin = newv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_N; i++) begin
				thr_q[i] <= '0;
			end
			mag_q  <= MAG_RESET;
			en_q   <= EN_RESET;
			done_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				thr_q[cfg_index] <= cfg_data;
			end
			if (fire && change) begin
				mag_q <= mag_q + (newv ? MAG_UP : MAG_DN);
				en_q  <= en_q + EN_W'(signed'(de));
			end
			done_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			flipped_q <= change;
			de_q      <= req.in_range ? de : '0;
			spin_q    <= req.in_range ? newv : 1'b0;
		end
	end

	assign done              = done_q;
	assign flipped           = flipped_q;
	assign delta_energy      = de_q;
	assign spin_now          = spin_q;
	assign magnetization_sum = mag_q;
	assign energy_sum        = en_q;

endmodule

/* rtl/ising_metropolis_spin_update_top.sv */
// Ising lattice single-spin-flip update: sequencer around one spin RAM (isingm_ram),
// the neighbour address unit (isingm_nbr) and the decision/sum unit (isingm_update).
// A request steps through S_MUL, S_DIV, one S_RDUP/S_RDDN pair per dimension and S_DEC:
// site read, coordinate split, one RAM read per neighbour, decide and write back.
// The result strobe (done) comes in the cycle after the write-back; the receiver cannot stall.
// After reset the RAM is swept to all down over all NSITES sites (4096 by default) with busy high.
module ising_metropolis_spin_update_top #(
	parameter int SIDE = 64,
	parameter int DIMS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [isingm_pkg::CMD_W-1:0]        command,
	input  logic [isingm_pkg::SITE_W-1:0]       site,
	input  logic [isingm_pkg::RND_W-1:0]        random_fraction,
	input  logic                                write_spin,
	input  logic                                cfg_write,
	input  logic [isingm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [isingm_pkg::RND_W-1:0]        cfg_data,
	output logic                                done,
	output logic                                flipped,
	output logic signed [isingm_pkg::DE_W-1:0]  delta_energy,
	output logic                                spin_now,
	output logic signed [isingm_pkg::MAG_W-1:0] magnetization_sum,
	output logic signed [isingm_pkg::EN_W-1:0]  energy_sum
);
	import isingm_pkg::*;

	localparam int NSITES = site_total(SIDE, DIMS);
	localparam int AW     = (NSITES > 1) ? $clog2(NSITES) : 1;
	localparam int DIM_W  = (DIMS > 1) ? $clog2(DIMS) : 1;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_RDUP  = 7'b0010000,
		S_RDDN  = 7'b0100000,
		S_DEC   = 7'b1000000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [AW-1:0]     clr_q;
	logic [DIM_W-1:0]  dim_q;
	logic [SITE_W-1:0] site_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [RND_W-1:0]  rnd_q;
	logic              wval_q;
	logic              me_q;
	logic [EQ_W-1:0]   eq_q;
	logic              oob_s1;

	logic              accept;
	logic              last_dim;
	logic              rd_bit;
	logic              eq_inc;
	logic [EQ_W-1:0]   eq_total;
	logic [AW-1:0]     ram_addr;
	logic              ram_we;
	logic              ram_wdata;
	logic              ram_rdata;
	logic [NB_W-1:0]   up_idx;
	logic [NB_W-1:0]   dn_idx;
	logic              up_oob;
	logic              dn_oob;
	nbr_ctrl_t         nbr_ctl;
	upd_req_t          upd_req;
	logic              upd_wr_en;
	logic              upd_wr_spin;

	assign busy     = !(state_q == S_IDLE || state_q == S_DEC);
	assign accept   = start && !busy;
	assign last_dim = dim_q == DIM_W'(DIMS - 1);
	// neighbours past the end of the store read as down
	assign rd_bit   = ram_rdata && !oob_s1;
	assign eq_inc   = rd_bit == me_q;
	assign eq_total = eq_q + EQ_W'(eq_inc);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == AW'(NSITES - 1)) state_d = S_IDLE;
			S_IDLE:  if (accept) state_d = S_MUL;
			S_MUL:   state_d = S_DIV;
			S_DIV:   state_d = S_RDUP;
			S_RDUP:  state_d = S_RDDN;
			S_RDDN:  state_d = last_dim ? S_DEC : S_RDUP;
			S_DEC:   state_d = accept ? S_MUL : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_CLEAR: ram_addr = clr_q;
			S_RDUP:  ram_addr = up_idx[AW-1:0];
			S_RDDN:  ram_addr = dn_idx[AW-1:0];
			default: ram_addr = site_q[AW-1:0];
		endcase
	end

	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_DEC && upd_wr_en);
	assign ram_wdata = (state_q == S_CLEAR) ? 1'b0 : upd_wr_spin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			dim_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == S_DIV) begin
				dim_q <= '0;
			end else if (state_q == S_RDDN && !last_dim) begin
				dim_q <= dim_q + DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			site_q <= site;
			cmd_q  <= command;
			rnd_q  <= random_fraction;
			wval_q <= write_spin;
		end
		unique case (state_q)
			S_DIV: begin
				me_q <= ram_rdata;
				eq_q <= '0;
			end
			S_RDUP: begin
				// count the down neighbour of the previous dimension
				if (dim_q != '0) begin
					eq_q <= eq_total;
				end
				oob_s1 <= up_oob;
			end
			S_RDDN: begin
				eq_q   <= eq_total;
				oob_s1 <= dn_oob;
			end
			default: begin
			end
		endcase
	end

	assign nbr_ctl.load = accept;
	assign nbr_ctl.mul  = (state_q == S_MUL) || (state_q == S_RDUP);
	assign nbr_ctl.div  = (state_q == S_DIV) || (state_q == S_RDDN && !last_dim);

	assign upd_req.cmd      = cmd_q;
	assign upd_req.rnd      = rnd_q;
	assign upd_req.wval     = wval_q;
	assign upd_req.me       = me_q;
	assign upd_req.in_range = {1'b0, site_q} < (SITE_W + 1)'(NSITES);

	isingm_ram #(
		.WIDTH(1),
		.DEPTH(NSITES)
	) u_ram (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	isingm_nbr #(
		.SIDE  (SIDE),
		.NSITES(NSITES)
	) u_nbr (
		.clk   (clk),
		.ctl   (nbr_ctl),
		.site  (site),
		.up_idx(up_idx),
		.dn_idx(dn_idx),
		.up_oob(up_oob),
		.dn_oob(dn_oob)
	);

	isingm_update #(
		.DIMS  (DIMS),
		.NSITES(NSITES)
	) u_update (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fire             (state_q == S_DEC),
		.req              (upd_req),
		.eq_cnt           (eq_total),
		.wr_en            (upd_wr_en),
		.wr_spin          (upd_wr_spin),
		.done             (done),
		.flipped          (flipped),
		.delta_energy     (delta_energy),
		.spin_now         (spin_now),
		.magnetization_sum(magnetization_sum),
		.energy_sum       (energy_sum)
	);

	a_done_after_dec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_DEC))
		else $error("result strobe without a decide cycle");

	a_up_then_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDUP) |=> (state_q == S_RDDN))
		else $error("neighbour read pair broken");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_DEC))
		else $error("spin RAM written outside clear or write-back");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (busy && !ram_wdata))
		else $error("clearing pass not holding off requests");

	a_dec_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEC && !start) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle");

endmodule
